// File: hw/rtl/tlvp_pkg.sv
`timescale 1ns / 1ps

package tlvp_pkg;

   // record type bytes
   localparam logic [7:0] TYPE_TOKEN     = 8'h01;
   localparam logic [7:0] TYPE_ROLE      = 8'h02;
   localparam logic [7:0] TYPE_NEIGHBORS = 8'h03;
   localparam logic [7:0] TYPE_PARAMS    = 8'h04;
   localparam logic [7:0] TYPE_EMU       = 8'h05;
   localparam logic [7:0] LEN_ESCAPE     = 8'hFF;

   localparam logic [15:0] TOKEN_BYTES = 16'd32;
   localparam logic [16:0] GROUP_BYTES = 17'd6;
   localparam logic [2:0]  GROUP_LAST  = 3'd5;

   // event codes
   localparam logic [1:0] EV_START   = 2'd0;
   localparam logic [1:0] EV_VALUE   = 2'd1;
   localparam logic [1:0] EV_DONE_OK = 2'd2;
   localparam logic [1:0] EV_DONE_ER = 2'd3;

   // field kinds
   localparam logic [2:0] KIND_ROLE      = 3'd0;
   localparam logic [2:0] KIND_TOKEN     = 3'd1;
   localparam logic [2:0] KIND_NEIGHBORS = 3'd2;
   localparam logic [2:0] KIND_PARAMS    = 3'd3;
   localparam logic [2:0] KIND_EMU       = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd5;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PHASE_TYPE,
      PHASE_LEN8,
      PHASE_EXTLO,
      PHASE_EXTHI,
      PHASE_VALUE
   } phase_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [2:0]  field_kind;
      logic [15:0] value_index;
      logic [7:0]  value_data;
      logic [15:0] record_length;
      logic        last_result;
   } result_type;

   // one accepted byte's worth of results: one or two
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } work_type;

   function automatic logic [2:0] kind_of(input logic [7:0] t);
      logic [2:0] k;
      case (t)
         TYPE_ROLE:      k = KIND_ROLE;
         TYPE_TOKEN:     k = KIND_TOKEN;
         TYPE_NEIGHBORS: k = KIND_NEIGHBORS;
         TYPE_PARAMS:    k = KIND_PARAMS;
         TYPE_EMU:       k = KIND_EMU;
         default:        k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic result_type finish_result(input logic err);
      result_type r;
      r = '0;
      r.event_res = err ? EV_DONE_ER : EV_DONE_OK;
      return r;
   endfunction

endpackage

// File: hw/rtl/topology_tlv_stream_parser.sv
`timescale 1ns / 1ps

// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+------------------
// request   | req_data_byte, req_has_byte, req_last_byte        | req_push / req_full
// response  | rsp_event_res, rsp_field_kind, rsp_value_index,   | rsp_pop / rsp_empty
//           | rsp_value_data, rsp_record_length, rsp_last_result|
//
// One input item is taken per cycle while the front-to-back queue (4 entries) has room.
// The response side delivers one result item per cycle while the consumer pops; an item that yields two results
// (record start plus finish, or value byte plus finish) holds its queue entry until both results are loaded.
// A result is written into the queue at the accepting edge and then loaded into the output register
// once that register is empty or being popped.
// Synchronous active-high reset clears the parser phase, queue pointers and output valid.
// A stalled response side backs up into the queue; req_full rises once it holds 4 items.

module topology_tlv_stream_parser import tlvp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_event_res,
   output logic [2:0]  rsp_field_kind,
   output logic [15:0] rsp_value_index,
   output logic [7:0]  rsp_value_data,
   output logic [15:0] rsp_record_length,
   output logic        rsp_last_result
);

   logic       accept;
   logic       work_push;
   work_type   work;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   work_type   q_head;
   result_type out_result;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: tracks record phase and classifies each byte
   tlvp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .last_byte (req_last_byte),
      .work_push (work_push),
      .work      (work)
   );

   // decouples parsing from a stalled consumer
   tlvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_work (work),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: serializes one or two results per entry into the output register
   tlvp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_pop    (rsp_pop),
      .out_empty  (rsp_empty),
      .out_result (out_result)
   );

   assign rsp_event_res     = out_result.event_res;
   assign rsp_field_kind    = out_result.field_kind;
   assign rsp_value_index   = out_result.value_index;
   assign rsp_value_data    = out_result.value_data;
   assign rsp_record_length = out_result.record_length;
   assign rsp_last_result   = out_result.last_result;

endmodule

// File: hw/rtl/tlvp_front.sv
`timescale 1ns / 1ps

module tlvp_front import tlvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       has_byte,
   input  logic       last_byte,
   output logic       work_push,
   output work_type   work
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] off_ff, off_in;
   logic [2:0]  grp_ff, grp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_TYPE;
         type_ff  <= '0;
         len_ff   <= '0;
         off_ff   <= '0;
         grp_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
         grp_ff   <= grp_in;
      end
   end

   always_comb begin
      logic        first_v;
      logic        fin_v;
      logic        fin_err;
      logic        used;
      logic [15:0] hdr_len;
      logic [15:0] next_off;
      result_type  first;

      first_v  = 1'b0;
      fin_v    = 1'b0;
      fin_err  = 1'b0;
      used     = 1'b0;
      hdr_len  = '0;
      next_off = off_ff + 16'd1;
      first    = '0;
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      off_in   = off_ff;
      grp_in   = grp_ff;

      if (accept) begin
         if (!has_byte) begin
            fin_v   = last_byte;
            fin_err = !(phase_ff == PHASE_TYPE || phase_ff == PHASE_LEN8);
         end else begin
            case (phase_ff)
               PHASE_TYPE: begin
                  if (last_byte) begin
                     fin_v = 1'b1;              // lone trailing byte
                  end else begin
                     type_in  = data_byte;
                     phase_in = PHASE_LEN8;
                  end
               end
               PHASE_LEN8: begin
                  if (data_byte == LEN_ESCAPE) begin
                     phase_in = PHASE_EXTLO;
                     fin_v    = last_byte;
                     fin_err  = 1'b1;
                  end else begin
                     first_v = 1'b1;
                     hdr_len = {8'h00, data_byte};
                  end
               end
               PHASE_EXTLO: begin
                  len_in   = {8'h00, data_byte};
                  phase_in = PHASE_EXTHI;
                  fin_v    = last_byte;
                  fin_err  = 1'b1;
               end
               PHASE_EXTHI: begin
                  first_v = 1'b1;
                  hdr_len = {data_byte, len_ff[7:0]};
               end
               PHASE_VALUE: begin
                  case (type_ff)
                     TYPE_ROLE:      used = (off_ff == '0);
                     TYPE_TOKEN:     used = (len_ff >= TOKEN_BYTES) && (off_ff < TOKEN_BYTES);
                     TYPE_NEIGHBORS: used = ({1'b0, off_ff - {13'd0, grp_ff}} + GROUP_BYTES)
                                            <= {1'b0, len_ff};
                     TYPE_PARAMS:    used = 1'b1;
                     TYPE_EMU:       used = (off_ff == '0);
                     default:        used = 1'b0;
                  endcase
                  first_v             = used;
                  first.event_res     = EV_VALUE;
                  first.field_kind    = kind_of(type_ff);
                  first.value_index   = off_ff;
                  first.value_data    = data_byte;
                  first.record_length = len_ff;
                  off_in = next_off;
                  grp_in = (grp_ff >= GROUP_LAST) ? 3'd0 : grp_ff + 3'd1;
                  fin_v  = last_byte;
                  if (next_off >= len_ff) begin
                     phase_in = PHASE_TYPE;
                  end else begin
                     fin_err = 1'b1;
                  end
               end
               default: begin
                  phase_in = PHASE_TYPE;
                  fin_v    = last_byte;
               end
            endcase

            // header complete: announce the record
            if (phase_ff == PHASE_LEN8 || phase_ff == PHASE_EXTHI) begin
               if (first_v) begin
                  first               = '0;
                  first.event_res     = EV_START;
                  first.field_kind    = kind_of(type_ff);
                  first.record_length = hdr_len;
                  len_in   = hdr_len;
                  off_in   = '0;
                  grp_in   = '0;
                  phase_in = (hdr_len == '0) ? PHASE_TYPE : PHASE_VALUE;
                  fin_v    = last_byte;
                  fin_err  = (hdr_len != '0);
               end
            end
         end
      end

      if (fin_v) begin
         phase_in = PHASE_TYPE;
         type_in  = '0;
         len_in   = '0;
         off_in   = '0;
         grp_in   = '0;
      end

      work_push = first_v || fin_v;
      work.two  = first_v && fin_v;
      work.r1   = finish_result(fin_err);
      work.r1.last_result = 1'b1;
      if (first_v) begin
         work.r0 = first;
         work.r0.last_result = !fin_v;
      end else begin
         work.r0 = finish_result(fin_err);
         work.r0.last_result = 1'b1;
      end
   end

endmodule

// File: hw/rtl/tlvp_queue.sv
`timescale 1ns / 1ps

module tlvp_queue import tlvp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_work,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output work_type head
);

   work_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_work;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count mismatch");

endmodule

// File: hw/rtl/tlvp_back.sv
`timescale 1ns / 1ps

module tlvp_back import tlvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  work_type   q_head,
   output logic       q_pop,
   input  logic       out_pop,
   output logic       out_empty,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   result_type out_ff, out_in;
   logic       load;

   assign load       = !q_empty && (!valid_ff || out_pop);
   assign q_pop      = load && (second_ff || !q_head.two);
   assign out_empty  = !valid_ff;
   assign out_result = out_ff;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      out_in    = out_ff;
      if (load) begin
         valid_in  = 1'b1;
         out_in    = second_ff ? q_head.r1 : q_head.r0;
         second_in = !second_ff && q_head.two;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !q_empty && q_head.two) else $error("second half without head");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tlvp_pkg::*;

   // one byte offered to the parser, plus its buffer flags
   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
   } tlv_byte_type;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int TAIL_ITEMS = 150;   // no new idle gaps start once fewer bytes than this remain
   localparam int HOLD_AT = 300;      // items taken before the long response stall
   localparam int HOLD_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [2:0]  rsp_field_kind;
   logic [15:0] rsp_value_index;
   logic [7:0]  rsp_value_data;
   logic [15:0] rsp_record_length;
   logic        rsp_last_result;

   topology_tlv_stream_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_last_byte     (req_last_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_res     (rsp_event_res),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_value_index   (rsp_value_index),
      .rsp_value_data    (rsp_value_data),
      .rsp_record_length (rsp_record_length),
      .rsp_last_result   (rsp_last_result)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Stimulus store and bookkeeping
   // ---------------------------------------------------------------------
   tlv_byte_type stream_bytes[$];       // items still to be offered
   result_type   parse_events_due[$];   // predicted results, oldest first
   result_type   step_events[$];        // results of the byte being decoded
   int           real_items = 0;        // items that are not idle markers
   int           items_taken = 0;
   int           mismatches = 0;
   int           cycles = 0;
   bit           byte_taken = 1'b0;     // set at the edge that accepts an item

   // ---------------------------------------------------------------------
   // Parser mirror: phase, header fields and value position
   // ---------------------------------------------------------------------
   phase_type   cur_phase = PHASE_TYPE;
   logic [7:0]  cur_type = '0;
   logic [15:0] cur_len = '0;
   logic [15:0] cur_off = '0;
   logic [2:0]  cur_grp = '0;
   logic        last_bad = 1'b0;     // outcome of the last finished buffer

   function automatic logic [2:0] kind_code(input logic [7:0] t);
      logic [2:0] k;
      case (t)
         TYPE_ROLE:      k = KIND_ROLE;
         TYPE_TOKEN:     k = KIND_TOKEN;
         TYPE_NEIGHBORS: k = KIND_NEIGHBORS;
         TYPE_PARAMS:    k = KIND_PARAMS;
         TYPE_EMU:       k = KIND_EMU;
         default:        k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic void push_event(input logic [1:0] ev, input logic [2:0] kind,
                                      input logic [15:0] idx, input logic [7:0] data,
                                      input logic [15:0] len);
      result_type r;
      r = '0;
      r.event_res = ev;
      r.field_kind = kind;
      r.value_index = idx;
      r.value_data = data;
      r.record_length = len;
      step_events = {step_events, r};
   endfunction

   // end of buffer: report outcome, drop back to waiting for a type byte
   function automatic void close_buffer(input logic err);
      push_event(err ? EV_DONE_ER : EV_DONE_OK, '0, '0, '0, '0);
      cur_phase = PHASE_TYPE;
      cur_type = '0;
      cur_len = '0;
      cur_off = '0;
      cur_grp = '0;
      last_bad = err;
   endfunction

   // header complete: announce the record; a nonzero length still owes values
   function automatic void open_value(input logic last);
      push_event(EV_START, kind_code(cur_type), '0, '0, cur_len);
      cur_off = '0;
      cur_grp = '0;
      if (cur_len == 0) begin
         cur_phase = PHASE_TYPE;
         if (last) close_buffer(1'b0);
      end else begin
         cur_phase = PHASE_VALUE;
         if (last) close_buffer(1'b1);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic has,
                                       input logic last);
      bit wanted;
      step_events.delete();
      if (!has) begin
         // empty end marker; without last it is a no-op
         if (last) close_buffer(!(cur_phase == PHASE_TYPE || cur_phase == PHASE_LEN8));
      end else begin
         case (cur_phase)
            PHASE_TYPE: begin
               if (last) close_buffer(1'b0);   // lone trailing byte is dropped
               else begin
                  cur_type = b;
                  cur_phase = PHASE_LEN8;
               end
            end
            PHASE_LEN8: begin
               if (b == LEN_ESCAPE) begin
                  if (last) close_buffer(1'b1);
                  else cur_phase = PHASE_EXTLO;
               end else begin
                  cur_len = {8'h00, b};
                  open_value(last);
               end
            end
            PHASE_EXTLO: begin
               cur_len = {8'h00, b};
               if (last) close_buffer(1'b1);
               else cur_phase = PHASE_EXTHI;
            end
            PHASE_EXTHI: begin
               cur_len[15:8] = b;
               open_value(last);
            end
            PHASE_VALUE: begin
               case (cur_type)
                  TYPE_ROLE:      wanted = (cur_off == 0);
                  TYPE_TOKEN:     wanted = (cur_len >= TOKEN_BYTES) && (cur_off < TOKEN_BYTES);
                  // only bytes of whole six-byte neighbor entries
                  TYPE_NEIGHBORS: wanted = (int'(cur_off) - int'(cur_grp)
                                            + int'(GROUP_BYTES)) <= int'(cur_len);
                  TYPE_PARAMS:    wanted = 1'b1;
                  TYPE_EMU:       wanted = (cur_off == 0);
                  default:        wanted = 1'b0;
               endcase
               if (wanted) push_event(EV_VALUE, kind_code(cur_type), cur_off, b, cur_len);
               cur_off = cur_off + 16'd1;
               cur_grp = (cur_grp >= GROUP_LAST) ? 3'd0 : cur_grp + 3'd1;
               if (cur_off >= cur_len) begin
                  cur_phase = PHASE_TYPE;
                  if (last) close_buffer(1'b0);
               end else if (last) begin
                  close_buffer(1'b1);   // value cut short voids the buffer
               end
            end
            default: begin
               cur_phase = PHASE_TYPE;
               if (last) close_buffer(1'b0);
            end
         endcase
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last_result = 1'b1;
      parse_events_due = {parse_events_due, step_events};
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   task automatic add_item(input logic [7:0] d, input logic h, input logic l);
      tlv_byte_type it;
      it.data = d;
      it.has = h;
      it.last = l;
      stream_bytes = {stream_bytes, it};
      if (h || l) real_items++;
   endtask

   // one record into body; a huge escaped length is left open so the
   // buffer ends inside its value
   task automatic append_record(ref logic [7:0] body[$], output bit open_end);
      logic [7:0] rtype;
      int         len;
      int         tail;
      open_end = 1'b0;
      case ($urandom_range(0, 9))
         0: begin rtype = TYPE_ROLE;      len = $urandom_range(0, 3);   end
         1: begin rtype = TYPE_TOKEN;     len = $urandom_range(28, 40); end
         2: begin rtype = TYPE_NEIGHBORS; len = $urandom_range(0, 19);  end
         3: begin rtype = TYPE_PARAMS;    len = $urandom_range(0, 6);   end
         4: begin rtype = TYPE_EMU;       len = $urandom_range(0, 3);   end
         default: begin
            rtype = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 8);
         end
      endcase
      body = {body, rtype};
      if ($urandom_range(0, 19) == 0) begin
         len = $urandom_range(256, 65535);
         body = {body, LEN_ESCAPE, len[7:0], len[15:8]};
         tail = $urandom_range(0, 8);
         repeat (tail) body = {body, 8'($urandom_range(0, 255))};
         open_end = 1'b1;
      end else begin
         if ($urandom_range(0, 4) == 0) begin
            body = {body, LEN_ESCAPE, len[7:0], 8'h00};
         end else begin
            body = {body, len[7:0]};
         end
         repeat (len) body = {body, 8'($urandom_range(0, 255))};
      end
   endtask

   // a whole buffer: mostly well-formed records, some noise, several endings
   task automatic append_buffer();
      logic [7:0] body[$];
      bit         open_end;
      int         nrec;
      int         ending;
      int         cut;
      open_end = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
         nrec = $urandom_range(1, 10);
         repeat (nrec) body = {body, 8'($urandom_range(0, 255))};
      end else begin
         nrec = $urandom_range(0, 4);
         for (int i = 0; i < nrec && !open_end; i++) append_record(body, open_end);
      end
      // 0..5 last on final byte, 6..7 end marker, 8 cut short, 9 lone trailing byte
      ending = open_end ? 0 : $urandom_range(0, 9);
      if (ending == 8 && body.size() > 1) begin
         cut = $urandom_range(1, body.size() - 1);
         while (body.size() > cut) body.delete(body.size() - 1);
      end else if (ending == 9) begin
         body = {body, 8'($urandom_range(0, 255))};
      end
      foreach (body[i]) begin
         if ($urandom_range(0, 29) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         add_item(body[i], 1'b1, (i == body.size() - 1) && !(ending inside {6, 7}));
      end
      if (body.size() == 0 || ending inside {6, 7})
         add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Sender: drives at the falling edge, holds an item until it is taken
   // ---------------------------------------------------------------------
   int send_gap = 0;
   int send_calm = 0;

   always @(posedge clock) begin : accept_side
      if (!reset && req_push && !req_full) begin
         decode_byte(req_data_byte, req_has_byte, req_last_byte);
         byte_taken = 1'b1;
         items_taken++;
      end
   end

   always @(negedge clock) begin : sender
      tlv_byte_type nxt;
      if (!reset && !(req_push && !byte_taken)) begin
         byte_taken = 1'b0;
         if (send_gap == 0 && send_calm == 0 && stream_bytes.size() >= TAIL_ITEMS
             && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 5);
            if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(20, 60);
         end
         if (send_calm > 0) send_calm--;
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (stream_bytes.size() > 0) begin
            nxt = stream_bytes.pop_front();
            req_data_byte <= nxt.data;
            req_has_byte <= nxt.has;
            req_last_byte <= nxt.last;
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random pop stalls, plus one long hold so the parser backs up
   // ---------------------------------------------------------------------
   int  recv_gap = 0;
   int  recv_calm = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(negedge clock) begin : receiver
      logic pop_n;
      pop_n = 1'b1;
      if (!hold_done && items_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop_n = 1'b0;
      end else begin
         if (recv_gap == 0 && recv_calm == 0 && stream_bytes.size() >= TAIL_ITEMS
             && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 5);
            if ($urandom_range(0, 3) == 0) recv_calm = $urandom_range(20, 60);
         end
         if (recv_calm > 0) recv_calm--;
         if (recv_gap > 0) begin
            recv_gap--;
            pop_n = 1'b0;
         end
      end
      rsp_pop <= reset ? 1'b0 : pop_n;
   end

   // ---------------------------------------------------------------------
   // Result check against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_side
      result_type got;
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.event_res = rsp_event_res;
         got.field_kind = rsp_field_kind;
         got.value_index = rsp_value_index;
         got.value_data = rsp_value_data;
         got.record_length = rsp_record_length;
         got.last_result = rsp_last_result;
         if (parse_events_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ev=%0d kind=%0d idx=%0d data=%02h len=%0d last=%0d",
                        got.event_res, got.field_kind, got.value_index, got.value_data,
                        got.record_length, got.last_result);
         end else begin
            want = parse_events_due.pop_front();
            if (got.event_res !== want.event_res || got.field_kind !== want.field_kind ||
                got.value_index !== want.value_index || got.value_data !== want.value_data ||
                got.record_length !== want.record_length ||
                got.last_result !== want.last_result) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: ev=%0d kind=%0d idx=%0d data=%02h len=%0d last=%0d",
                           want.event_res, want.field_kind, want.value_index,
                           want.value_data, want.record_length, want.last_result);
                  $display("         got: ev=%0d kind=%0d idx=%0d data=%02h len=%0d last=%0d",
                           got.event_res, got.field_kind, got.value_index, got.value_data,
                           got.record_length, got.last_result);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed cases, then random buffers; wait for drain and report
   // ---------------------------------------------------------------------
   initial begin
      // idle marker with no end: nothing happens; then an empty buffer
      add_item(8'hA5, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      // role with one byte, buffer ends on the value
      add_item(TYPE_ROLE, 1'b1, 1'b0);
      add_item(8'h01, 1'b1, 1'b0);
      add_item(8'h7F, 1'b1, 1'b1);
      // emu count of zero length ends on its length byte
      add_item(TYPE_EMU, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);
      // role params cut short after one value byte
      add_item(TYPE_PARAMS, 1'b1, 1'b0);
      add_item(8'h02, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b1);
      // neighbors with an escaped zero length
      add_item(TYPE_NEIGHBORS, 1'b1, 1'b0);
      add_item(LEN_ESCAPE, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);
      // lone trailing type byte is ignored
      add_item(8'h09, 1'b1, 1'b1);
      // type byte then an empty end marker
      add_item(TYPE_TOKEN, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      // buffer ends inside the escaped length
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(LEN_ESCAPE, 1'b1, 1'b0);
      add_item(8'h34, 1'b1, 1'b1);
      // large escaped length, buffer ends right on the header
      add_item(TYPE_ROLE, 1'b1, 1'b0);
      add_item(LEN_ESCAPE, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b1);

      while (real_items < RANDOM_ITEMS) append_buffer();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_push || parse_events_due.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && parse_events_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
